FILE: sv/qrsa_pkg.sv
// ----------------------------------------------------------------------------
// qrsa_pkg
// Shared widths, register map and configuration type for the quad to
// rectangle source address generator.
// ----------------------------------------------------------------------------
package qrsa_pkg;

    localparam int unsigned CORNER_W = 24;
    localparam int unsigned RECT_W   = 12;
    localparam int unsigned SRC_W    = 13;
    localparam int unsigned OUT_W    = 12;
    localparam int unsigned IDX_W    = 24;
    localparam int unsigned DIV_W    = 2 * RECT_W;

    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned SEL_W    = 3;

    localparam logic [SEL_W-1:0] REG_CORNER_A   = 3'd0;
    localparam logic [SEL_W-1:0] REG_CORNER_B   = 3'd1;
    localparam logic [SEL_W-1:0] REG_CORNER_C   = 3'd2;
    localparam logic [SEL_W-1:0] REG_CORNER_D   = 3'd3;
    localparam logic [SEL_W-1:0] REG_RECT_WIDTH = 3'd4;
    localparam logic [SEL_W-1:0] REG_RECT_HEIGHT = 3'd5;
    localparam logic [SEL_W-1:0] REG_SRC_WIDTH  = 3'd6;
    localparam logic [SEL_W-1:0] REG_SRC_HEIGHT = 3'd7;

    typedef struct packed {
        logic [CORNER_W-1:0] corner_a;
        logic [CORNER_W-1:0] corner_b;
        logic [CORNER_W-1:0] corner_c;
        logic [CORNER_W-1:0] corner_d;
        logic [RECT_W-1:0]   rect_width;
        logic [RECT_W-1:0]   rect_height;
        logic [SRC_W-1:0]    src_width;
        logic [SRC_W-1:0]    src_height;
    } t_cfg;

endpackage

FILE: sv/qrsa_regs.sv
// ----------------------------------------------------------------------------
// qrsa_regs
// Configuration register file on the APB-style port, plus the registered
// divisor (effective width times effective height).
// ----------------------------------------------------------------------------
module qrsa_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qrsa_pkg::ADDR_W-1:0]   paddr,
    input  logic [qrsa_pkg::DATA_W-1:0]   pwdata,
    output logic [qrsa_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output qrsa_pkg::t_cfg                o_cfg,
    output logic [qrsa_pkg::DIV_W-1:0]    o_divisor
);
    import qrsa_pkg::*;

    t_cfg               r_cfg;
    t_cfg               n_cfg;
    logic [DIV_W-1:0]   r_div;
    logic [DIV_W-1:0]   n_div;
    logic [SEL_W-1:0]   w_sel;
    logic               w_wr;
    logic [RECT_W-1:0]  w_weff;
    logic [RECT_W-1:0]  w_heff;

    assign pready = 1'b1;
    assign w_sel  = paddr[ADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite & pready;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_sel)
                REG_CORNER_A:    n_cfg.corner_a    = pwdata[CORNER_W-1:0];
                REG_CORNER_B:    n_cfg.corner_b    = pwdata[CORNER_W-1:0];
                REG_CORNER_C:    n_cfg.corner_c    = pwdata[CORNER_W-1:0];
                REG_CORNER_D:    n_cfg.corner_d    = pwdata[CORNER_W-1:0];
                REG_RECT_WIDTH:  n_cfg.rect_width  = pwdata[RECT_W-1:0];
                REG_RECT_HEIGHT: n_cfg.rect_height = pwdata[RECT_W-1:0];
                REG_SRC_WIDTH:   n_cfg.src_width   = pwdata[SRC_W-1:0];
                REG_SRC_HEIGHT:  n_cfg.src_height  = pwdata[SRC_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_sel)
            REG_CORNER_A:    prdata = DATA_W'(r_cfg.corner_a);
            REG_CORNER_B:    prdata = DATA_W'(r_cfg.corner_b);
            REG_CORNER_C:    prdata = DATA_W'(r_cfg.corner_c);
            REG_CORNER_D:    prdata = DATA_W'(r_cfg.corner_d);
            REG_RECT_WIDTH:  prdata = DATA_W'(r_cfg.rect_width);
            REG_RECT_HEIGHT: prdata = DATA_W'(r_cfg.rect_height);
            REG_SRC_WIDTH:   prdata = DATA_W'(r_cfg.src_width);
            REG_SRC_HEIGHT:  prdata = DATA_W'(r_cfg.src_height);
            default:         prdata = '0;
        endcase
    end

    assign w_weff = (r_cfg.rect_width == '0) ? RECT_W'(1) : r_cfg.rect_width;
    assign w_heff = (r_cfg.rect_height == '0) ? RECT_W'(1) : r_cfg.rect_height;
    assign n_div  = DIV_W'(w_weff) * DIV_W'(w_heff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{corner_a: '0, corner_b: '0, corner_c: '0, corner_d: '0,
                       rect_width: '0, rect_height: '0,
                       src_width: SRC_W'(1), src_height: SRC_W'(1)};
            r_div <= DIV_W'(1);
        end else begin
            r_cfg <= n_cfg;
            r_div <= n_div;
        end
    end

    assign o_cfg     = r_cfg;
    assign o_divisor = r_div;

endmodule

FILE: sv/qrsa_blend.sv
// ----------------------------------------------------------------------------
// qrsa_blend
// Five-stage pipeline that forms the bilinear numerators for x and y:
// clamp, edge weights, edge sums, span weights, final sum.
// ----------------------------------------------------------------------------
module qrsa_blend #(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_vld,
    input  logic [qrsa_pkg::RECT_W-1:0]                   i_row,
    input  logic [qrsa_pkg::RECT_W-1:0]                   i_col,
    input  qrsa_pkg::t_cfg                                i_cfg,
    output logic                                          o_vld,
    output logic [2*qrsa_pkg::RECT_W+COORD_BITS-1:0]      o_num [2]
);
    import qrsa_pkg::*;

    localparam int unsigned CW2    = 2 * COORD_BITS;
    localparam int unsigned EDGE_W = RECT_W + COORD_BITS;
    localparam int unsigned NUM_W  = 2 * RECT_W + COORD_BITS;

    logic [CW2-1:0]        w_ext_a;
    logic [CW2-1:0]        w_ext_b;
    logic [CW2-1:0]        w_ext_c;
    logic [CW2-1:0]        w_ext_d;
    logic [COORD_BITS-1:0] w_ca [2];
    logic [COORD_BITS-1:0] w_cb [2];
    logic [COORD_BITS-1:0] w_cc [2];
    logic [COORD_BITS-1:0] w_cd [2];

    logic [RECT_W-1:0]     w_h;
    logic [RECT_W-1:0]     w_w;
    logic [RECT_W-1:0]     w_i;
    logic [RECT_W-1:0]     w_j;

    logic [4:0]            r_vld;
    logic [RECT_W-1:0]     r_s1_i;
    logic [RECT_W-1:0]     r_s1_j;
    logic [RECT_W-1:0]     r_s1_hi;
    logic [RECT_W-1:0]     r_s1_wj;
    logic [RECT_W-1:0]     r_s2_j;
    logic [RECT_W-1:0]     r_s2_wj;
    logic [EDGE_W-1:0]     r_s2_pa [2];
    logic [EDGE_W-1:0]     r_s2_pb [2];
    logic [EDGE_W-1:0]     r_s2_pc [2];
    logic [EDGE_W-1:0]     r_s2_pd [2];
    logic [RECT_W-1:0]     r_s3_j;
    logic [RECT_W-1:0]     r_s3_wj;
    logic [EDGE_W-1:0]     r_s3_left [2];
    logic [EDGE_W-1:0]     r_s3_right [2];
    logic [NUM_W-1:0]      r_s4_ml [2];
    logic [NUM_W-1:0]      r_s4_mr [2];
    logic [NUM_W-1:0]      r_s5_num [2];

    assign w_ext_a = CW2'(i_cfg.corner_a);
    assign w_ext_b = CW2'(i_cfg.corner_b);
    assign w_ext_c = CW2'(i_cfg.corner_c);
    assign w_ext_d = CW2'(i_cfg.corner_d);

    assign w_ca[0] = w_ext_a[COORD_BITS-1:0];
    assign w_ca[1] = w_ext_a[CW2-1:COORD_BITS];
    assign w_cb[0] = w_ext_b[COORD_BITS-1:0];
    assign w_cb[1] = w_ext_b[CW2-1:COORD_BITS];
    assign w_cc[0] = w_ext_c[COORD_BITS-1:0];
    assign w_cc[1] = w_ext_c[CW2-1:COORD_BITS];
    assign w_cd[0] = w_ext_d[COORD_BITS-1:0];
    assign w_cd[1] = w_ext_d[CW2-1:COORD_BITS];

    // clamp to the rectangle; a zero span weighs the first edge fully
    always_comb begin
        if (i_cfg.rect_height == '0) begin
            w_h = RECT_W'(1);
            w_i = '0;
        end else begin
            w_h = i_cfg.rect_height;
            w_i = (i_row > i_cfg.rect_height) ? i_cfg.rect_height : i_row;
        end
        if (i_cfg.rect_width == '0) begin
            w_w = RECT_W'(1);
            w_j = '0;
        end else begin
            w_w = i_cfg.rect_width;
            w_j = (i_col > i_cfg.rect_width) ? i_cfg.rect_width : i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_i  <= w_i;
        r_s1_j  <= w_j;
        r_s1_hi <= w_h - w_i;
        r_s1_wj <= w_w - w_j;

        r_s2_j  <= r_s1_j;
        r_s2_wj <= r_s1_wj;
        r_s3_j  <= r_s2_j;
        r_s3_wj <= r_s2_wj;

        for (int l = 0; l < 2; l++) begin
            r_s2_pa[l]    <= EDGE_W'(r_s1_hi) * EDGE_W'(w_ca[l]);
            r_s2_pb[l]    <= EDGE_W'(r_s1_hi) * EDGE_W'(w_cb[l]);
            r_s2_pc[l]    <= EDGE_W'(r_s1_i) * EDGE_W'(w_cc[l]);
            r_s2_pd[l]    <= EDGE_W'(r_s1_i) * EDGE_W'(w_cd[l]);
            r_s3_left[l]  <= r_s2_pa[l] + r_s2_pd[l];
            r_s3_right[l] <= r_s2_pb[l] + r_s2_pc[l];
            r_s4_ml[l]    <= NUM_W'(r_s3_wj) * NUM_W'(r_s3_left[l]);
            r_s4_mr[l]    <= NUM_W'(r_s3_j) * NUM_W'(r_s3_right[l]);
            r_s5_num[l]   <= r_s4_ml[l] + r_s4_mr[l];
        end
    end

    assign o_vld    = r_vld[4];
    assign o_num[0] = r_s5_num[0];
    assign o_num[1] = r_s5_num[1];

endmodule

FILE: sv/qrsa_div.sv
// ----------------------------------------------------------------------------
// qrsa_div
// Pipelined restoring divider, two lanes sharing one divisor. One quotient
// bit per stage, most significant first.
// ----------------------------------------------------------------------------
module qrsa_div #(
    parameter int unsigned NUM_W = 36,
    parameter int unsigned DEN_W = 24,
    parameter int unsigned Q_W   = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  logic [NUM_W-1:0] i_num [2],
    input  logic [DEN_W-1:0] i_den,
    output logic             o_vld,
    output logic [Q_W-1:0]   o_quo [2]
);

    logic [NUM_W-1:0] w_rem_in [Q_W][2];
    logic [Q_W-1:0]   w_quo_in [Q_W][2];
    logic [NUM_W-1:0] w_dsh    [Q_W];
    logic             w_ge     [Q_W][2];
    logic [NUM_W-1:0] n_rem    [Q_W-1][2];
    logic [NUM_W-1:0] r_rem    [Q_W-1][2];
    logic [Q_W-1:0]   n_quo    [Q_W][2];
    logic [Q_W-1:0]   r_quo    [Q_W][2];
    logic [Q_W-1:0]   r_vld;

    for (genvar s = 0; s < Q_W; s++) begin : g_step
        localparam int unsigned SH = Q_W - 1 - s;

        assign w_dsh[s] = NUM_W'(i_den) << SH;

        for (genvar l = 0; l < 2; l++) begin : g_lane
            if (s == 0) begin : g_first
                assign w_rem_in[s][l] = i_num[l];
                assign w_quo_in[s][l] = '0;
            end else begin : g_next
                assign w_rem_in[s][l] = r_rem[s-1][l];
                assign w_quo_in[s][l] = r_quo[s-1][l];
            end

            assign w_ge[s][l]  = (w_rem_in[s][l] >= w_dsh[s]);
            assign n_quo[s][l] = w_quo_in[s][l] | (Q_W'(w_ge[s][l]) << SH);

            if (s < Q_W - 1) begin : g_rem
                assign n_rem[s][l] = w_ge[s][l] ? (w_rem_in[s][l] - w_dsh[s])
                                                : w_rem_in[s][l];
                always_ff @(posedge i_clk) begin
                    r_rem[s][l] <= n_rem[s][l];
                end
            end

            always_ff @(posedge i_clk) begin
                r_quo[s][l] <= n_quo[s][l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[Q_W-2:0], i_vld};
        end
    end

    assign o_vld    = r_vld[Q_W-1];
    assign o_quo[0] = r_quo[Q_W-1][0];
    assign o_quo[1] = r_quo[Q_W-1][1];

endmodule

FILE: sv/quad_to_rect_source_address_top.sv
// ----------------------------------------------------------------------------
// quad_to_rect_source_address_top
// Bilinear quad to rectangle source address generator: maps a destination
// pixel onto a source quadrilateral and returns coordinates, linear index
// and an outside-of-image flag.
// ----------------------------------------------------------------------------
// The block takes one destination pixel per clock: busy is always low, and
// each result appears on the output ports for one cycle with o_done high.
// The receiver cannot stall the block, so results must be taken as they
// come. The pipelined divider resolves one quotient bit per stage; the
// remaining stages are the bilinear blend (five) and the index multiply and
// range check (two). Configuration registers are to be written through the
// APB port only while no item is in flight; the block does not enforce this.
module quad_to_rect_source_address_top #(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [qrsa_pkg::RECT_W-1:0]  i_dst_row,
    input  logic [qrsa_pkg::RECT_W-1:0]  i_dst_col,
    output logic                         o_done,
    output logic [qrsa_pkg::OUT_W-1:0]   o_sample_x,
    output logic [qrsa_pkg::OUT_W-1:0]   o_sample_y,
    output logic [qrsa_pkg::IDX_W-1:0]   o_sample_index,
    output logic                         o_outside,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [qrsa_pkg::ADDR_W-1:0]  paddr,
    input  logic [qrsa_pkg::DATA_W-1:0]  pwdata,
    output logic [qrsa_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import qrsa_pkg::*;

    localparam int unsigned NUM_W = 2 * RECT_W + COORD_BITS;
    localparam int unsigned PW    = COORD_BITS + SRC_W;

    t_cfg                  w_cfg;
    logic [DIV_W-1:0]      w_divisor;
    logic                  w_blend_vld;
    logic [NUM_W-1:0]      w_num [2];
    logic                  w_div_vld;
    logic [COORD_BITS-1:0] w_quo [2];
    logic [PW-1:0]         w_prod;
    logic [PW-1:0]         w_qx_ext;
    logic [PW-1:0]         w_qy_ext;
    logic [PW-1:0]         w_sw_ext;
    logic [PW-1:0]         w_sh_ext;

    logic                  r_a_vld;
    logic [COORD_BITS-1:0] r_a_qx;
    logic [COORD_BITS-1:0] r_a_qy;
    logic [IDX_W-1:0]      r_a_prod;
    logic                  r_done;
    logic [OUT_W-1:0]      r_x;
    logic [OUT_W-1:0]      r_y;
    logic [IDX_W-1:0]      r_index;
    logic                  r_outside;
    logic [IDX_W-1:0]      n_index;
    logic                  n_outside;

    assign busy = 1'b0;

    qrsa_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (w_cfg),
        .o_divisor (w_divisor)
    );

    qrsa_blend #(
        .COORD_BITS (COORD_BITS)
    ) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start & ~busy),
        .i_row   (i_dst_row),
        .i_col   (i_dst_col),
        .i_cfg   (w_cfg),
        .o_vld   (w_blend_vld),
        .o_num   (w_num)
    );

    qrsa_div #(
        .NUM_W (NUM_W),
        .DEN_W (DIV_W),
        .Q_W   (COORD_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_blend_vld),
        .i_num   (w_num),
        .i_den   (w_divisor),
        .o_vld   (w_div_vld),
        .o_quo   (w_quo)
    );

    assign w_prod = PW'(w_quo[1]) * PW'(w_cfg.src_width);

    assign w_qx_ext = PW'(r_a_qx);
    assign w_qy_ext = PW'(r_a_qy);
    assign w_sw_ext = PW'(w_cfg.src_width);
    assign w_sh_ext = PW'(w_cfg.src_height);

    assign n_index   = r_a_prod + IDX_W'(r_a_qx);
    assign n_outside = (w_qx_ext >= w_sw_ext) || (w_qy_ext >= w_sh_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_a_vld <= w_div_vld;
            r_done  <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_qx    <= w_quo[0];
        r_a_qy    <= w_quo[1];
        r_a_prod  <= IDX_W'(w_prod);
        r_x       <= OUT_W'(r_a_qx);
        r_y       <= OUT_W'(r_a_qy);
        r_index   <= n_index;
        r_outside <= n_outside;
    end

    assign o_done         = r_done;
    assign o_sample_x     = r_x;
    assign o_sample_y     = r_y;
    assign o_sample_index = r_index;
    assign o_outside      = r_outside;

endmodule

FILE: test/qrsa_checker.sv
// ----------------------------------------------------------------------------
// qrsa_checker
// Watches the pixel, result and register ports of the quad to rectangle
// source address generator, keeps its own copy of the mapping registers,
// predicts every sample address and compares the results in order.
// ----------------------------------------------------------------------------
module qrsa_checker #(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [qrsa_pkg::RECT_W-1:0] dst_row,
    input  logic [qrsa_pkg::RECT_W-1:0] dst_col,
    input  logic                        done,
    input  logic [qrsa_pkg::OUT_W-1:0]  sample_x,
    input  logic [qrsa_pkg::OUT_W-1:0]  sample_y,
    input  logic [qrsa_pkg::IDX_W-1:0]  sample_index,
    input  logic                        outside,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [qrsa_pkg::ADDR_W-1:0] paddr,
    input  logic [qrsa_pkg::DATA_W-1:0] pwdata,
    output int                          fail_count,
    output int                          pending_count,
    output int                          checked_count,
    output int                          outside_count
);
    import qrsa_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic [IDX_W-1:0] index;
        logic             outside;
    } t_sample;

    localparam logic [63:0] COORD_MASK = (64'd1 << COORD_BITS) - 64'd1;

    t_cfg    mapping;
    t_sample expected_samples[$];
    t_sample want;

    function automatic logic [63:0] coord_x(input logic [CORNER_W-1:0] corner);
        return 64'(corner) & COORD_MASK;
    endfunction

    function automatic logic [63:0] coord_y(input logic [CORNER_W-1:0] corner);
        return (64'(corner) >> COORD_BITS) & COORD_MASK;
    endfunction

    function automatic logic [63:0] blend(input logic [63:0] a, b, c, d, i, j, w, h);
        logic [63:0] left_edge;
        logic [63:0] right_edge;
        logic [63:0] num;
        left_edge  = (h - i) * a + i * d;
        right_edge = (h - i) * b + i * c;
        num        = (w - j) * left_edge + j * right_edge;
        return num / (w * h);
    endfunction

    function automatic t_sample predict_sample(input t_cfg c,
                                               input logic [RECT_W-1:0] row,
                                               input logic [RECT_W-1:0] col);
        logic [63:0] i, j, w, h, x, y;
        t_sample     s;
        i = 64'(row);
        j = 64'(col);
        w = 64'(c.rect_width);
        h = 64'(c.rect_height);
        if (i > h) i = h;
        if (j > w) j = w;
        if (h == 0) begin
            h = 1;
            i = 0;
        end
        if (w == 0) begin
            w = 1;
            j = 0;
        end
        x = blend(coord_x(c.corner_a), coord_x(c.corner_b), coord_x(c.corner_c),
                  coord_x(c.corner_d), i, j, w, h);
        y = blend(coord_y(c.corner_a), coord_y(c.corner_b), coord_y(c.corner_c),
                  coord_y(c.corner_d), i, j, w, h);
        s.x       = x[OUT_W-1:0];
        s.y       = y[OUT_W-1:0];
        s.index   = IDX_W'(y * 64'(c.src_width) + x);
        s.outside = (x >= 64'(c.src_width)) || (y >= 64'(c.src_height));
        return s;
    endfunction

    task automatic check_field(input string name, input logic [IDX_W-1:0] expected,
                               input logic [IDX_W-1:0] actual);
        if (expected !== actual) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, expected, actual);
            fail_count++;
        end
    endtask

    initial begin
        fail_count    = 0;
        pending_count = 0;
        checked_count = 0;
        outside_count = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mapping = '0;
            mapping.src_width  = SRC_W'(1);
            mapping.src_height = SRC_W'(1);
            expected_samples.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_CORNER_A:    mapping.corner_a    = pwdata[CORNER_W-1:0];
                    REG_CORNER_B:    mapping.corner_b    = pwdata[CORNER_W-1:0];
                    REG_CORNER_C:    mapping.corner_c    = pwdata[CORNER_W-1:0];
                    REG_CORNER_D:    mapping.corner_d    = pwdata[CORNER_W-1:0];
                    REG_RECT_WIDTH:  mapping.rect_width  = pwdata[RECT_W-1:0];
                    REG_RECT_HEIGHT: mapping.rect_height = pwdata[RECT_W-1:0];
                    REG_SRC_WIDTH:   mapping.src_width   = pwdata[SRC_W-1:0];
                    REG_SRC_HEIGHT:  mapping.src_height  = pwdata[SRC_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                expected_samples.push_back(predict_sample(mapping, dst_row, dst_col));
            if (done) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t: result with none expected, actual x 0x%0h y 0x%0h",
                             $time, sample_x, sample_y);
                    fail_count++;
                end else begin
                    want = expected_samples.pop_front();
                    check_field("sample_x", IDX_W'(want.x), IDX_W'(sample_x));
                    check_field("sample_y", IDX_W'(want.y), IDX_W'(sample_y));
                    check_field("sample_index", want.index, sample_index);
                    check_field("outside", IDX_W'(want.outside), IDX_W'(outside));
                    checked_count++;
                    if (want.outside)
                        outside_count++;
                end
            end
        end
        pending_count = expected_samples.size();
    end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives destination pixels and mapping register writes into the quad to
// rectangle source address generator: a directed pass over corner extremes
// and degenerate rectangles, then randomized mappings and pixels under
// varying sender gaps. Checking is done by qrsa_checker.
// ----------------------------------------------------------------------------
module tb;
    import qrsa_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [RECT_W-1:0] i_dst_row;
    logic [RECT_W-1:0] i_dst_col;
    logic              o_done;
    logic [OUT_W-1:0]  o_sample_x;
    logic [OUT_W-1:0]  o_sample_y;
    logic [IDX_W-1:0]  o_sample_index;
    logic              o_outside;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int pending_count;
    int checked_count;
    int outside_count;
    int idle_pct;
    int pixels_sent;
    int settings_loaded;
    int cur_w;
    int cur_h;
    logic [DATA_W-1:0] rw, rh, sw, sh;

    quad_to_rect_source_address_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_dst_row      (i_dst_row),
        .i_dst_col      (i_dst_col),
        .o_done         (o_done),
        .o_sample_x     (o_sample_x),
        .o_sample_y     (o_sample_y),
        .o_sample_index (o_sample_index),
        .o_outside      (o_outside),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    qrsa_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .dst_row       (i_dst_row),
        .dst_col       (i_dst_col),
        .done          (o_done),
        .sample_x      (o_sample_x),
        .sample_y      (o_sample_y),
        .sample_index  (o_sample_index),
        .outside       (o_outside),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count),
        .outside_count (outside_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 400000);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic issue_pixel(input logic [RECT_W-1:0] row, input logic [RECT_W-1:0] col);
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start     = 1'b1;
        i_dst_row = row;
        i_dst_col = col;
        do @(posedge i_clk); while (busy);
        pixels_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_count != 0)
            @(negedge i_clk);
    endtask

    task automatic reg_write(input logic [SEL_W-1:0] sel, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {sel, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic load_mapping(input logic [DATA_W-1:0] a, b, c, d,
                                input logic [DATA_W-1:0] w, h, src_w, src_h);
        reg_write(REG_CORNER_A, a);
        reg_write(REG_CORNER_B, b);
        reg_write(REG_CORNER_C, c);
        reg_write(REG_CORNER_D, d);
        reg_write(REG_RECT_WIDTH, w);
        reg_write(REG_RECT_HEIGHT, h);
        reg_write(REG_SRC_WIDTH, src_w);
        reg_write(REG_SRC_HEIGHT, src_h);
        cur_w = int'(w[RECT_W-1:0]);
        cur_h = int'(h[RECT_W-1:0]);
        settings_loaded++;
    endtask

    function automatic logic [DATA_W-1:0] pick_span();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DATA_W'(4095);
            2:       return DATA_W'($urandom_range(0, 4095));
            default: return DATA_W'($urandom_range(1, 48));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_src();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DATA_W'(8191);
            2:       return DATA_W'(4096);
            default: return DATA_W'($urandom_range(1, 4096));
        endcase
    endfunction

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_dst_row       = '0;
        i_dst_col       = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        idle_pct        = 0;
        pixels_sent     = 0;
        settings_loaded = 0;
        cur_w           = 0;
        cur_h           = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset mapping: degenerate rectangle, 1x1 source
        issue_pixel(12'd0, 12'd0);
        issue_pixel(12'd4095, 12'd4095);
        wait_drained();

        load_mapping(32'h000000, 32'h000FFF, 32'hFFFFFF, 32'hFFF000, 4095, 4095, 4096, 4096);
        issue_pixel(12'd0, 12'd0);
        issue_pixel(12'd0, 12'd4095);
        issue_pixel(12'd4095, 12'd0);
        issue_pixel(12'd4095, 12'd4095);
        issue_pixel(12'd1234, 12'd2049);
        wait_drained();

        // zero source width, pixels past the rectangle
        load_mapping($urandom, $urandom, $urandom, $urandom, 10, 7, 0, 8191);
        issue_pixel(12'd3, 12'd20);
        issue_pixel(12'd4095, 12'd4095);
        issue_pixel(12'd7, 12'd10);
        issue_pixel(12'd0, 12'd5);
        wait_drained();

        // zero rectangle width, zero source height
        load_mapping($urandom, $urandom, $urandom, $urandom, 0, 5, 4096, 0);
        issue_pixel(12'd2, 12'd3000);
        issue_pixel(12'd5, 12'd0);
        issue_pixel(12'd9, 12'd9);
        wait_drained();

        // zero rectangle height
        load_mapping($urandom, $urandom, $urandom, $urandom, 6, 0, 100, 100);
        issue_pixel(12'd0, 12'd3);
        issue_pixel(12'd100, 12'd6);
        issue_pixel(12'd0, 12'd0);
        wait_drained();

        // all corners at the far end, index wraps
        load_mapping(32'hFFFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 4095, 4095, 8191, 1);
        issue_pixel(12'd0, 12'd0);
        issue_pixel(12'd4095, 12'd4095);
        issue_pixel(12'd2000, 12'd100);
        wait_drained();

        for (int ph = 0; ph < 11; ph++) begin
            idle_pct = (ph < 4) ? 18 : (ph < 8) ? 88 : 0;
            rw = pick_span() | ($urandom & 32'hFFFF_F000);
            rh = pick_span() | ($urandom & 32'hFFFF_F000);
            sw = pick_src() | ($urandom & 32'hFFFF_E000);
            sh = pick_src() | ($urandom & 32'hFFFF_E000);
            load_mapping($urandom, $urandom, $urandom, $urandom, rw, rh, sw, sh);
            for (int n = 0; n < 50; n++) begin
                if ($urandom_range(0, 9) == 0)
                    issue_pixel(RECT_W'($urandom), RECT_W'($urandom));
                else
                    issue_pixel(RECT_W'($urandom_range(0, cur_h)),
                                RECT_W'($urandom_range(0, cur_w)));
            end
            wait_drained();
        end

        repeat (40) @(posedge i_clk);
        $display("Sent %0d destination pixels across %0d mapping settings,", pixels_sent,
                 settings_loaded);
        $display("compared %0d sample addresses, %0d of them outside the source image.",
                 checked_count, outside_count);
        if (pending_count != 0)
            $display("%0d expected results never arrived", pending_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/qrsa_pkg.sv
sv/qrsa_regs.sv
sv/qrsa_blend.sv
sv/qrsa_div.sv
sv/quad_to_rect_source_address_top.sv
test/qrsa_checker.sv
test/tb.sv
